### design/mfs_pkg.sv
package mfs_pkg;

    // Configuration register widths
    localparam int TICK_W   = 10;
    localparam int SETTLE_W = 16;
    localparam int SLIP_W   = 16;
    localparam int SPDERR_W = 15;
    localparam int HOLD_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP_MM      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_ERR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_HOLD_MS  = 3'd4;

    // Configuration reset values
    localparam logic [TICK_W-1:0]   TICK_MS_RST   = 10'd10;
    localparam logic [SETTLE_W-1:0] SETTLE_MS_RST = 16'd1000;
    localparam logic [SLIP_W-1:0]   SLIP_MM_RST   = 16'd500;
    localparam logic [SPDERR_W-1:0] SPD_ERR_RST   = 15'd200;
    localparam logic [HOLD_W-1:0]   HOLD_MS_RST   = 16'd1500;

    // Timers saturate at all ones
    localparam int TIMER_W = 17;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Recovery limits for the follow check
    localparam int MIN_MOVE_MM_S = 10;
    localparam int MIN_PRODUCT   = 1000;

    // Fault bit positions
    localparam int FAULT_W      = 5;
    localparam int FB_BRAKE_L   = 0;
    localparam int FB_BRAKE_R   = 1;
    localparam int FB_MOVE_L    = 2;
    localparam int FB_MOVE_R    = 3;
    localparam int FB_STOP      = 4;

    typedef enum logic [1:0] {
        BRAKE_IDLE   = 2'd0,
        BRAKE_SETTLE = 2'd1,
        BRAKE_WATCH  = 2'd2
    } t_brake_phase;

    typedef enum logic [1:0] {
        FOLLOW_TRACK   = 2'd0,
        FOLLOW_TIMING  = 2'd1,
        FOLLOW_FAILING = 2'd2,
        FOLLOW_FAILED  = 2'd3
    } t_follow_phase;

    typedef struct packed {
        logic clr;
        logic set;
    } t_follow_flags;

    function automatic logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] t,
                                                      input logic [TICK_W-1:0] d);
        logic [TIMER_W:0] s;
        s = {1'b0, t} + (TIMER_W+1)'(d);
        return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

endpackage

### design/mfs_follow.sv
module mfs_follow
    import mfs_pkg::*;
#(
    parameter int SPEED_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic signed [SPEED_BITS-1:0] i_cmd,
    input  logic signed [SPEED_BITS-1:0] i_meas,
    input  logic [TICK_W-1:0]            i_tick_ms,
    input  logic [SPDERR_W-1:0]          i_err_th,
    input  logic [HOLD_W-1:0]            i_hold_ms,
    output t_follow_flags                o_flags
);

    localparam int ERR_W  = SPEED_BITS + 1;
    localparam int CMP_W  = (ERR_W > SPDERR_W) ? ERR_W : SPDERR_W;
    localparam int PROD_W = 2 * SPEED_BITS;
    localparam logic signed [PROD_W-1:0] MIN_PROD_S = PROD_W'(MIN_PRODUCT);
    localparam logic [ERR_W-1:0]         MIN_MOVE_U = ERR_W'(MIN_MOVE_MM_S);

    t_follow_phase               r_phase;
    t_follow_phase               n_phase;
    t_follow_phase               phase_eff;
    logic [TIMER_W-1:0]          r_timer;
    logic [TIMER_W-1:0]          n_timer;
    logic [TIMER_W-1:0]          timer_inc;
    logic signed [ERR_W-1:0]     diff;
    logic signed [ERR_W-1:0]     meas_x;
    logic [ERR_W-1:0]            err;
    logic [ERR_W-1:0]            meas_abs;
    logic signed [PROD_W-1:0]    prod;
    logic                        err_lt;
    logic                        err_gt;
    logic                        recover;

    assign diff     = {i_cmd[SPEED_BITS-1], i_cmd} - {i_meas[SPEED_BITS-1], i_meas};
    assign err      = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
    assign meas_x   = {i_meas[SPEED_BITS-1], i_meas};
    assign meas_abs = meas_x[ERR_W-1] ? ERR_W'(-meas_x) : ERR_W'(meas_x);
    assign prod     = PROD_W'(i_cmd) * PROD_W'(i_meas);

    assign err_lt  = CMP_W'(err) < CMP_W'(i_err_th);
    assign err_gt  = CMP_W'(err) > CMP_W'(i_err_th);
    assign recover = err_lt || ((meas_abs > MIN_MOVE_U) && (prod > MIN_PROD_S));

    assign phase_eff = recover ? FOLLOW_TRACK : r_phase;
    assign timer_inc = timer_add(r_timer, i_tick_ms);

    always_comb begin
        n_phase = phase_eff;
        unique case (phase_eff)
            FOLLOW_TRACK: begin
                if (err_gt) n_phase = FOLLOW_TIMING;
            end
            FOLLOW_TIMING: begin
                if (timer_inc > {1'b0, i_hold_ms}) n_phase = FOLLOW_FAILING;
            end
            FOLLOW_FAILING: n_phase = FOLLOW_FAILED;
            FOLLOW_FAILED:  n_phase = FOLLOW_FAILED;
            default:        n_phase = FOLLOW_TRACK;
        endcase
    end

    always_comb begin
        n_timer     = r_timer;
        o_flags.clr = recover;
        o_flags.set = 1'b0;
        unique case (phase_eff)
            FOLLOW_TRACK: begin
                if (err_gt) n_timer = '0;
            end
            FOLLOW_TIMING: n_timer = timer_inc;
            FOLLOW_FAILING, FOLLOW_FAILED: o_flags.set = 1'b1;
            default: o_flags.set = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= FOLLOW_TRACK;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    // Timer is always cleared on entry to timing, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_timer <= n_timer;
        end
    end

endmodule

### design/motor_fault_supervisor_core.sv
// Per-tick fault supervisor for a two-wheel drive: forces commands to zero under
// brake, park lock or emergency stop, latches park-brake slip per wheel, flags
// wheels that do not follow their command, and tracks the emergency-stop fault.
// Throughput is one tick per clock while results are taken. o_out_valid rises
// once a tick has passed the input register and then the result register that
// also holds the fault flags. o_in_ready drops only while the result register is
// full and not taken. Configuration writes are always accepted and must be issued
// while idle. SPEED_BITS and DIST_BITS set the speed and odometer port widths.
module motor_fault_supervisor_core
    import mfs_pkg::*;
#(
    parameter int SPEED_BITS = 16,
    parameter int DIST_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_service_brake,
    input  logic                         i_park_lock,
    input  logic                         i_emergency_stop,
    input  logic signed [SPEED_BITS-1:0] i_cmd_speed_left,
    input  logic signed [SPEED_BITS-1:0] i_cmd_speed_right,
    input  logic signed [SPEED_BITS-1:0] i_meas_speed_left,
    input  logic signed [SPEED_BITS-1:0] i_meas_speed_right,
    input  logic signed [DIST_BITS-1:0]  i_odometer_left,
    input  logic signed [DIST_BITS-1:0]  i_odometer_right,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_drive_inhibit,
    output logic                         o_brake_fail_left,
    output logic                         o_brake_fail_right,
    output logic                         o_move_fail_left,
    output logic                         o_move_fail_right,
    output logic                         o_stop_active,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int DIFF_W = DIST_BITS + 1;

    // Configuration
    logic [TICK_W-1:0]   r_tick_ms;
    logic [SETTLE_W-1:0] r_settle_ms;
    logic [SLIP_W-1:0]   r_slip_mm;
    logic [SPDERR_W-1:0] r_err_th;
    logic [HOLD_W-1:0]   r_hold_ms;

    // Input register
    logic                         r_in_valid;
    logic                         r_in_brake;
    logic                         r_in_lock;
    logic                         r_in_stop;
    logic signed [SPEED_BITS-1:0] r_in_cmd_l;
    logic signed [SPEED_BITS-1:0] r_in_cmd_r;
    logic signed [SPEED_BITS-1:0] r_in_meas_l;
    logic signed [SPEED_BITS-1:0] r_in_meas_r;
    logic signed [DIST_BITS-1:0]  r_in_odo [2];

    // Supervisor state
    logic                        r_stop_prev;
    t_brake_phase                r_brake_phase;
    t_brake_phase                n_brake_phase;
    t_brake_phase                brake_eff;
    logic [TIMER_W-1:0]          r_brake_timer;
    logic [TIMER_W-1:0]          n_brake_timer;
    logic [TIMER_W-1:0]          brake_timer_inc;
    logic signed [DIST_BITS-1:0] r_lock_pos [2];
    logic signed [DIST_BITS-1:0] n_lock_pos [2];
    logic [1:0]                  r_slip_rep;
    logic [1:0]                  n_slip_rep;
    logic [1:0]                  slip_set;
    logic [1:0]                  slip_over;
    logic [FAULT_W-1:0]          r_fault;
    logic [FAULT_W-1:0]          n_fault;

    // Result register
    logic r_out_valid;
    logic r_out_inhibit;

    logic                         in_xfer;
    logic                         out_free;
    logic                         step;
    logic                         inhibit;
    logic                         settle_done;
    logic signed [SPEED_BITS-1:0] cmd_l;
    logic signed [SPEED_BITS-1:0] cmd_r;
    t_follow_flags                follow_l;
    t_follow_flags                follow_r;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || out_free;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign step        = r_in_valid && out_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms   <= TICK_MS_RST;
            r_settle_ms <= SETTLE_MS_RST;
            r_slip_mm   <= SLIP_MM_RST;
            r_err_th    <= SPD_ERR_RST;
            r_hold_ms   <= HOLD_MS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TICK_MS:     r_tick_ms   <= i_cfg_data[TICK_W-1:0];
                CFG_SETTLE_MS:   r_settle_ms <= i_cfg_data[SETTLE_W-1:0];
                CFG_SLIP_MM:     r_slip_mm   <= i_cfg_data[SLIP_W-1:0];
                CFG_SPEED_ERR:   r_err_th    <= i_cfg_data[SPDERR_W-1:0];
                CFG_ERR_HOLD_MS: r_hold_ms   <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_brake  <= i_service_brake;
            r_in_lock   <= i_park_lock;
            r_in_stop   <= i_emergency_stop;
            r_in_cmd_l  <= i_cmd_speed_left;
            r_in_cmd_r  <= i_cmd_speed_right;
            r_in_meas_l <= i_meas_speed_left;
            r_in_meas_r <= i_meas_speed_right;
            r_in_odo[0] <= i_odometer_left;
            r_in_odo[1] <= i_odometer_right;
        end
    end

    assign inhibit = r_in_brake || r_in_lock || r_in_stop;
    assign cmd_l   = inhibit ? '0 : r_in_cmd_l;
    assign cmd_r   = inhibit ? '0 : r_in_cmd_r;

    // Park brake supervisor
    assign brake_eff       = r_in_lock ? r_brake_phase : BRAKE_IDLE;
    assign brake_timer_inc = timer_add(r_brake_timer, r_tick_ms);
    assign settle_done     = brake_timer_inc > {1'b0, r_settle_ms};

    always_comb begin
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        mag;
        for (int w = 0; w < 2; w++) begin
            d   = {r_lock_pos[w][DIST_BITS-1], r_lock_pos[w]}
                - {r_in_odo[w][DIST_BITS-1], r_in_odo[w]};
            mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            slip_over[w] = mag > DIFF_W'(r_slip_mm);
        end
    end

    always_comb begin
        n_brake_phase = brake_eff;
        unique case (brake_eff)
            BRAKE_IDLE: begin
                if (r_in_lock) n_brake_phase = BRAKE_SETTLE;
            end
            BRAKE_SETTLE: begin
                if (settle_done) n_brake_phase = BRAKE_WATCH;
            end
            default: n_brake_phase = BRAKE_WATCH;
        endcase
    end

    always_comb begin
        n_brake_timer = r_brake_timer;
        n_lock_pos    = r_lock_pos;
        n_slip_rep    = r_slip_rep;
        slip_set      = 2'b00;
        unique case (brake_eff)
            BRAKE_IDLE: begin
                if (r_in_lock) begin
                    n_brake_timer = '0;
                    n_slip_rep    = 2'b00;
                end
            end
            BRAKE_SETTLE: begin
                n_brake_timer = brake_timer_inc;
                if (settle_done) begin
                    n_lock_pos = r_in_odo;
                end
            end
            default: begin
                // Report each wheel once per lock engagement
                slip_set   = slip_over & ~r_slip_rep;
                n_slip_rep = r_slip_rep | slip_set;
            end
        endcase
    end

    mfs_follow #(
        .SPEED_BITS (SPEED_BITS)
    ) u_follow_l (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_cmd     (cmd_l),
        .i_meas    (r_in_meas_l),
        .i_tick_ms (r_tick_ms),
        .i_err_th  (r_err_th),
        .i_hold_ms (r_hold_ms),
        .o_flags   (follow_l)
    );

    mfs_follow #(
        .SPEED_BITS (SPEED_BITS)
    ) u_follow_r (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_cmd     (cmd_r),
        .i_meas    (r_in_meas_r),
        .i_tick_ms (r_tick_ms),
        .i_err_th  (r_err_th),
        .i_hold_ms (r_hold_ms),
        .o_flags   (follow_r)
    );

    always_comb begin
        n_fault = r_fault;
        n_fault[FB_BRAKE_L] = r_fault[FB_BRAKE_L] | slip_set[0];
        n_fault[FB_BRAKE_R] = r_fault[FB_BRAKE_R] | slip_set[1];
        n_fault[FB_MOVE_L]  = (r_fault[FB_MOVE_L] & ~follow_l.clr) | follow_l.set;
        n_fault[FB_MOVE_R]  = (r_fault[FB_MOVE_R] & ~follow_r.clr) | follow_r.set;
        // Stop edge comes last: a press wipes every fault from this tick too
        if (r_in_stop != r_stop_prev) begin
            if (r_in_stop) begin
                n_fault = '0;
                n_fault[FB_STOP] = 1'b1;
            end else begin
                n_fault[FB_STOP] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_prev   <= 1'b0;
            r_brake_phase <= BRAKE_IDLE;
            r_brake_timer <= '0;
            r_slip_rep    <= 2'b00;
            r_fault       <= '0;
        end else if (step) begin
            r_stop_prev   <= r_in_stop;
            r_brake_phase <= n_brake_phase;
            r_brake_timer <= n_brake_timer;
            r_slip_rep    <= n_slip_rep;
            r_fault       <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_lock_pos    <= n_lock_pos;
            r_out_inhibit <= inhibit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Fault flags change only on a step, so they double as the result fields
    assign o_out_valid        = r_out_valid;
    assign o_drive_inhibit    = r_out_inhibit;
    assign o_brake_fail_left  = r_fault[FB_BRAKE_L];
    assign o_brake_fail_right = r_fault[FB_BRAKE_R];
    assign o_move_fail_left   = r_fault[FB_MOVE_L];
    assign o_move_fail_right  = r_fault[FB_MOVE_R];
    assign o_stop_active      = r_fault[FB_STOP];

endmodule

### design/mfs_checker.sv
module mfs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_drive_inhibit,
    input logic o_brake_fail_left,
    input logic o_brake_fail_right,
    input logic o_move_fail_left,
    input logic o_move_fail_right,
    input logic o_stop_active
);

    // Result register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // Input side stalls only behind a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty result register");

    // Stop fault is only held while stop is pressed, which inhibits drive
    a_stop_inhibit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stop_active |-> o_drive_inhibit)
        else $error("stop fault without drive inhibit");

    // Held result keeps its flags
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive_inhibit)
            && $stable(o_brake_fail_left) && $stable(o_brake_fail_right)
            && $stable(o_move_fail_left) && $stable(o_move_fail_right)
            && $stable(o_stop_active))
        else $error("result changed while stalled");

endmodule

bind motor_fault_supervisor_core mfs_checker u_mfs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_drive_inhibit    (o_drive_inhibit),
    .o_brake_fail_left  (o_brake_fail_left),
    .o_brake_fail_right (o_brake_fail_right),
    .o_move_fail_left   (o_move_fail_left),
    .o_move_fail_right  (o_move_fail_right),
    .o_stop_active      (o_stop_active)
);
